FILE: hw/rtl/sdcb_pkg.sv
// Shared types, codes and the LFSR tap table for the set-dueling bypass block.
`default_nettype none

package sdcb_pkg;

  // Request command codes.
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  // Request kind codes. The fourth code is handled like KIND_OTHER.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  // Set class codes reported with every result.
  localparam logic [1:0] CLASS_FOLLOWER = 2'd0;
  localparam logic [1:0] CLASS_BYPASS   = 2'd1;
  localparam logic [1:0] CLASS_FILL     = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_EPOCH_LIMIT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP_THRESH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BYPASS_CHNC  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BYPASS_SLOT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_SLOT    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LFSR_SEED    = 3'd5;
  localparam int unsigned CFG_DATA_W  = 17;

  // Register reset values.
  localparam logic [16:0] EPOCH_LIMIT_RST   = 17'd16384;
  localparam logic [7:0]  GAP_THRESH_RST    = 8'd16;
  localparam logic [15:0] BYPASS_CHANCE_RST = 16'd58982;
  localparam logic [4:0]  BYPASS_SLOT_RST   = 5'd0;
  localparam logic [4:0]  FILL_SLOT_RST     = 5'd2;

  // Address bits that select the set slot.
  localparam int unsigned SLOT_LSB = 10;
  localparam int unsigned SLOT_W   = 5;

  // Request queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_RUN,
    ST_MUL,
    ST_SCALE,
    ST_CMP
  } state_t;

  // Configuration register contents.
  typedef struct packed {
    logic [16:0] epoch_limit;
    logic [7:0]  gap_threshold;
    logic [15:0] bypass_chance;
    logic [4:0]  bypass_slot;
    logic [4:0]  fill_slot;
  } cfg_t;

  // Decoded request as it sits in the queue.
  typedef struct packed {
    logic is_access;
    logic counted;
    logic miss;
    logic in_b;
    logic in_f;
    logic draw_always;
    logic draw_follow;
  } item_t;

  // Galois feedback masks, by register width.
  function automatic logic [31:0] lfsr_taps(input int unsigned bits);
    logic [31:0] taps;
    case (bits)
      8:       taps = 32'h8E;
      9:       taps = 32'h108;
      10:      taps = 32'h204;
      11:      taps = 32'h402;
      12:      taps = 32'h829;
      13:      taps = 32'h100D;
      14:      taps = 32'h2015;
      15:      taps = 32'h4001;
      16:      taps = 32'h8016;
      17:      taps = 32'h10004;
      18:      taps = 32'h20013;
      19:      taps = 32'h40013;
      20:      taps = 32'h80004;
      21:      taps = 32'h100002;
      22:      taps = 32'h200001;
      23:      taps = 32'h400010;
      24:      taps = 32'h80000D;
      25:      taps = 32'h1000004;
      26:      taps = 32'h2000023;
      27:      taps = 32'h4000013;
      28:      taps = 32'h8000004;
      29:      taps = 32'h10000002;
      30:      taps = 32'h20000029;
      31:      taps = 32'h40000004;
      32:      taps = 32'h80000057;
      default: taps = 32'h8E;
    endcase
    return taps;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sdcb_front.sv
// Front end: decodes and classifies each incoming request.
`default_nettype none

module sdcb_front import sdcb_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [47:0] addr,
  input  logic [1:0]  kind,
  input  logic        hit,
  input  cfg_t        cfg,
  input  logic        q_full,
  output logic        push,
  output item_t       item
);

  logic [SLOT_W-1:0] slot;
  logic              in_b;
  logic              in_f;
  logic              fill_draw;

  // Set slot match against both sample slots.
  assign slot = addr[SLOT_LSB +: SLOT_W];
  assign in_b = (slot == cfg.bypass_slot);
  assign in_f = (slot == cfg.fill_slot);

  // Write fills never draw.
  assign fill_draw = (cmd == CMD_FILL) && (kind != KIND_WRITE);

  // Build the queue entry.
  always_comb begin
    item.is_access   = (cmd == CMD_ACCESS);
    item.counted     = (cmd == CMD_ACCESS) && ((kind == KIND_READ) || (kind == KIND_WRITE));
    item.miss        = (kind == KIND_READ) && !hit;
    item.in_b        = in_b;
    item.in_f        = in_f;
    item.draw_always = fill_draw && in_b;
    item.draw_follow = fill_draw && !in_b && !in_f;
  end

  // Accept whenever the queue has room.
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

`default_nettype wire

FILE: hw/rtl/sdcb_fifo.sv
// Short request queue that decouples the front end from the back end.
`default_nettype none

module sdcb_fifo import sdcb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sdcb_back.sv
// Back end: sample counters, epoch mode evaluation, LFSR draws and the result register.
`default_nettype none

module sdcb_back import sdcb_pkg::*; #(
  parameter int COUNTER_BITS = 17,
  parameter int LFSR_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        seed_load,
  input  logic [15:0] seed,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        bypass,
  output logic        fill_mode,
  output logic [1:0]  sample_class,
  output logic        epoch_end
);

  localparam int PW = 2 * COUNTER_BITS;
  localparam int QW = PW + 8;
  localparam int SW = PW + 9;
  localparam int LW = (COUNTER_BITS > 17) ? COUNTER_BITS : 17;
  localparam logic [LFSR_BITS-1:0] TAPS = LFSR_BITS'(lfsr_taps(LFSR_BITS));

  state_t                  state;
  state_t                  state_next;
  logic [COUNTER_BITS-1:0] ba, bm, fa, fm;
  logic [COUNTER_BITS-1:0] ba_inc, bm_inc, fa_inc, fm_inc;
  logic [COUNTER_BITS-1:0] snap_ba, snap_bm, snap_fa, snap_fm;
  logic [PW-1:0]           p_bf, p_fb, p_ba;
  logic [QW-1:0]           scaled;
  logic [SW-1:0]           lhs, rhs;
  logic [1:0]              item_class;
  logic [1:0]              hold_class;
  logic                    mode;
  logic [LFSR_BITS-1:0]    lfsr;
  logic [LFSR_BITS-1:0]    lfsr_step;
  logic [LFSR_BITS-1:0]    seed_raw;
  logic [LFSR_BITS-1:0]    seed_fit;
  logic [15:0]             draw;
  logic                    out_free;
  logic                    epoch_hit;
  logic                    draw_en;
  logic                    draw_bit;
  logic                    gap_lt;
  logic                    run_load;
  logic                    eval_start;
  logic                    eval_done;

  assign out_free = !out_valid || out_ready;

  // Saturating counter updates for this request.
  always_comb begin
    ba_inc = ba;
    bm_inc = bm;
    fa_inc = fa;
    fm_inc = fm;
    if (q_item.counted && q_item.in_b) begin
      if (ba != '1) ba_inc = ba + 1'b1;
      if (q_item.miss && (bm != '1)) bm_inc = bm + 1'b1;
    end
    if (q_item.counted && q_item.in_f) begin
      if (fa != '1) fa_inc = fa + 1'b1;
      if (q_item.miss && (fm != '1)) fm_inc = fm + 1'b1;
    end
  end

  // Any access request may close an epoch.
  assign epoch_hit = q_item.is_access &&
                     ((LW'(ba_inc) >= LW'(cfg.epoch_limit)) ||
                      (LW'(fa_inc) >= LW'(cfg.epoch_limit)));

  // Set class of the request at the queue head.
  always_comb begin
    if (q_item.in_b) begin
      item_class = CLASS_BYPASS;
    end else if (q_item.in_f) begin
      item_class = CLASS_FILL;
    end else begin
      item_class = CLASS_FOLLOWER;
    end
  end

  // One Galois step and the 16-bit draw taken from the new state.
  assign lfsr_step = (lfsr >> 1) ^ (lfsr[0] ? TAPS : '0);

  generate
    if (LFSR_BITS >= 16) begin : g_wide
      assign draw     = lfsr_step[LFSR_BITS-1 -: 16];
      assign seed_raw = LFSR_BITS'(seed);
    end else begin : g_narrow
      assign draw     = {lfsr_step, {(16 - LFSR_BITS){1'b0}}};
      assign seed_raw = seed[LFSR_BITS-1:0];
    end
  endgenerate

  assign seed_fit = (seed_raw == '0) ? LFSR_BITS'(1) : seed_raw;
  assign draw_en  = q_item.draw_always || (q_item.draw_follow && mode);
  assign draw_bit = draw_en && (draw < cfg.bypass_chance);

  // Miss-rate gap test: 256*bm*fa < 256*fm*ba + threshold*ba*fa.
  assign lhs    = {1'b0, p_bf, 8'b0};
  assign rhs    = {1'b0, p_fb, 8'b0} + SW'(scaled);
  assign gap_lt = (lhs < rhs);

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN:   if (eval_start) state_next = ST_MUL;
      ST_MUL:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_CMP;
      ST_CMP:   if (out_free) state_next = ST_RUN;
      default:  state_next = ST_RUN;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop      = 1'b0;
    eval_done  = 1'b0;
    case (state)
      ST_RUN:   q_pop = q_valid && out_free;
      ST_CMP:   eval_done = out_free;
      default:  q_pop = 1'b0;
    endcase
    run_load   = q_pop && !epoch_hit;
    eval_start = q_pop && epoch_hit;
  end

  // Control state, counters, mode and random state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      ba        <= '0;
      bm        <= '0;
      fa        <= '0;
      fm        <= '0;
      mode      <= 1'b0;
      lfsr      <= LFSR_BITS'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (seed_load) begin
        lfsr <= seed_fit;
      end else if (run_load && draw_en) begin
        lfsr <= lfsr_step;
      end
      if (run_load) begin
        ba <= ba_inc;
        bm <= bm_inc;
        fa <= fa_inc;
        fm <= fm_inc;
      end else if (eval_start) begin
        ba <= ba_inc >> 1;
        bm <= bm_inc >> 1;
        fa <= fa_inc >> 1;
        fm <= fm_inc >> 1;
      end
      if (eval_done) begin
        mode <= gap_lt;
      end
      if (run_load || eval_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Evaluation datapath: snapshot, three products, then the threshold scaling.
  always_ff @(posedge clk) begin
    if (eval_start) begin
      snap_ba    <= ba_inc;
      snap_bm    <= bm_inc;
      snap_fa    <= fa_inc;
      snap_fm    <= fm_inc;
      hold_class <= item_class;
    end
    if (state == ST_MUL) begin
      p_bf <= snap_bm * snap_fa;
      p_fb <= snap_fm * snap_ba;
      p_ba <= snap_ba * snap_fa;
    end
    if (state == ST_SCALE) begin
      scaled <= p_ba * cfg.gap_threshold;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (run_load) begin
      bypass       <= draw_bit;
      fill_mode    <= mode;
      sample_class <= item_class;
      epoch_end    <= 1'b0;
    end else if (eval_done) begin
      bypass       <= 1'b0;
      fill_mode    <= gap_lt;
      sample_class <= hold_class;
      epoch_end    <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/set_dueling_cache_bypass.sv
// A request goes into the queue; the back end pops it into the result register.
// One request per cycle while results are taken; a request that closes an epoch
// holds the back end while the two-stage multiply and the gap compare run.
// A four-entry queue lets the front keep accepting during that evaluation.
// Reset (synchronous, active high) clears counters, mode, queue and result valid,
// loads the register defaults and sets the random state to one.
`default_nettype none

module set_dueling_cache_bypass import sdcb_pkg::*; #(
  parameter int COUNTER_BITS = 17,
  parameter int LFSR_BITS    = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic [47:0]            addr,
  input  logic [1:0]             kind,
  input  logic                   hit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   bypass,
  output logic                   fill_mode,
  output logic [1:0]             sample_class,
  output logic                   epoch_end,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  cfg_write;
  logic  seed_load;
  logic  push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  item_t front_item;
  item_t q_item;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign seed_load = cfg_write && (cfg_index == REG_LFSR_SEED);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.epoch_limit   <= EPOCH_LIMIT_RST;
      cfg.gap_threshold <= GAP_THRESH_RST;
      cfg.bypass_chance <= BYPASS_CHANCE_RST;
      cfg.bypass_slot   <= BYPASS_SLOT_RST;
      cfg.fill_slot     <= FILL_SLOT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EPOCH_LIMIT: cfg.epoch_limit   <= cfg_data[16:0];
        REG_GAP_THRESH:  cfg.gap_threshold <= cfg_data[7:0];
        REG_BYPASS_CHNC: cfg.bypass_chance <= cfg_data[15:0];
        REG_BYPASS_SLOT: cfg.bypass_slot   <= cfg_data[4:0];
        REG_FILL_SLOT:   cfg.fill_slot     <= cfg_data[4:0];
        default:         ;
      endcase
    end
  end

  // Request decode and classification.
  sdcb_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .addr     (addr),
    .kind     (kind),
    .hit      (hit),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .item     (front_item)
  );

  // Decoupling queue.
  sdcb_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  // Policy state and result generation.
  sdcb_back #(
    .COUNTER_BITS (COUNTER_BITS),
    .LFSR_BITS    (LFSR_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .seed_load    (seed_load),
    .seed         (cfg_data[15:0]),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bypass       (bypass),
    .fill_mode    (fill_mode),
    .sample_class (sample_class),
    .epoch_end    (epoch_end)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/sdcb_checker.sv
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module sdcb_checker import sdcb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       bypass,
  input logic       fill_mode,
  input logic [1:0] sample_class,
  input logic       epoch_end
);

  logic last_mode;
  logic seen;

  // Mode carried by the last delivered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      last_mode <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen      <= 1'b1;
      last_mode <= fill_mode;
    end
  end

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bypass) && $stable(fill_mode) &&
                                $stable(sample_class) && $stable(epoch_end))
    else $error("result changed while stalled");

  // The mode only changes on a result that closes an epoch.
  a_mode_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && seen && !epoch_end |-> fill_mode == last_mode)
    else $error("mode changed outside an epoch end");

  // Fill-sample sets always fill.
  a_fill_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && bypass |-> sample_class != CLASS_FILL)
    else $error("bypass reported in a fill-sample set");

  // Epoch ends come from access requests, which never bypass.
  a_epoch_access: assert property (@(posedge clk) disable iff (rst)
    out_valid && epoch_end |-> !bypass)
    else $error("bypass reported on an epoch end");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind set_dueling_cache_bypass sdcb_checker u_sdcb_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .bypass       (bypass),
  .fill_mode    (fill_mode),
  .sample_class (sample_class),
  .epoch_end    (epoch_end)
);

`default_nettype wire
